[hw/rtl/lcs_pkg.sv]
// lcs_pkg: shared types and constants for the LRU cache set unit.
// Used by lcs_cell, lru_cache_set_unit and lcs_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 32;
  localparam int TAG_W     = ADDR_BITS;
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int CNT_W     = $clog2(MAX_WAYS + 1);
  localparam int OP_W      = 2;
  localparam int WAYS_CFG_W  = 4;
  localparam int SHIFT_CFG_W = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SHIFT   = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_EVICT  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // per-cycle action applied along the chain of cells
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_PUSH,
    ACT_CLOSE
  } act_t;

  // broadcast to every cell for the tag compare
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } cmp_t;

  // broadcast to every cell for the stack update
  typedef struct packed {
    act_t             act;
    logic [WAY_W-1:0] pos;
  } upd_t;

endpackage

`default_nettype wire

[hw/rtl/lcs_cell.sv]
// lcs_cell: one entry of the recency stack with its own tag comparator.
// Depends on lcs_pkg; instantiated in a row by lru_cache_set_unit.
`timescale 1ns / 1ps
`default_nettype none

module lcs_cell (
  input  logic                      clk,
  input  logic [lcs_pkg::WAY_W-1:0] cell_idx,
  input  lcs_pkg::cmp_t             cmp,
  input  lcs_pkg::upd_t             upd,
  input  logic [lcs_pkg::TAG_W-1:0] prev_tag,
  input  logic [lcs_pkg::TAG_W-1:0] next_tag,
  output logic [lcs_pkg::TAG_W-1:0] tag_o,
  output logic                      match_o
);

  logic [lcs_pkg::TAG_W-1:0] tag_r;
  logic [lcs_pkg::TAG_W-1:0] tag_nxt;
  logic                      valid;

  assign valid   = ({1'b0, cell_idx} < cmp.count);
  assign match_o = valid && (tag_r == cmp.tag);
  assign tag_o   = tag_r;

  always_comb begin
    tag_nxt = tag_r;
    case (upd.act)
      lcs_pkg::ACT_PUSH: begin
        // cells up to pos move one place towards LRU, cell 0 takes the new tag
        if (cell_idx == '0) begin
          tag_nxt = cmp.tag;
        end else if (cell_idx <= upd.pos) begin
          tag_nxt = prev_tag;
        end
      end
      lcs_pkg::ACT_CLOSE: begin
        if (cell_idx >= upd.pos) begin
          tag_nxt = next_tag;
        end
      end
      default: begin
        tag_nxt = tag_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/lru_cache_set_unit.sv]
// lru_cache_set_unit: one LRU-ordered set of a set-associative cache.
// Depends on lcs_pkg and lcs_cell.
`timescale 1ns / 1ps
`default_nettype none

// One item per clock cycle when not stalled. An accepted item's tag is compared
// against all eight cells at once, the first matching cell is picked and the
// whole stack shifts by at most one place in the same cycle; the result is
// registered and shown the cycle after acceptance. Input is stalled only while
// that result register is full and the output side stalls. The stack holds tags
// most recently used first; entries beyond the occupancy are don't-care. The user
// writes configuration via cfg_we/cfg_index/cfg_wdata only while idle; not enforced.
module lru_cache_set_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lcs_pkg::OP_W-1:0]        in_opcode,
  input  logic [lcs_pkg::ADDR_BITS-1:0]   in_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic                            out_hit,
  output logic [lcs_pkg::TAG_W-1:0]       out_victim_tag,
  output logic [lcs_pkg::CNT_W-1:0]       out_occupancy,
  input  logic                            cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [lcs_pkg::WAYS_CFG_W-1:0]  ways_r;
  logic [lcs_pkg::SHIFT_CFG_W-1:0] shift_r;
  logic [lcs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            ok_r, hit_r;
  logic [lcs_pkg::TAG_W-1:0]       victim_r;
  logic                            ok_c, hit_c;
  logic [lcs_pkg::TAG_W-1:0]       victim_c;

  logic                            accept;
  logic [lcs_pkg::CNT_W-1:0]       cap;
  lcs_pkg::cmp_t                   cmp;
  lcs_pkg::upd_t                   upd;
  lcs_pkg::op_t                    op;
  logic [lcs_pkg::MAX_WAYS-1:0]    match_vec;
  logic [lcs_pkg::TAG_W-1:0]       cell_tag [lcs_pkg::MAX_WAYS];
  logic                            any_hit;
  logic [lcs_pkg::WAY_W-1:0]       hit_pos;
  logic [lcs_pkg::CNT_W-1:0]       last_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign op       = lcs_pkg::op_t'(in_opcode);

  assign cmp.tag   = in_address >> shift_r;
  assign cmp.count = cnt_r;

  // zero acts as one, anything above the cell count as the cell count
  always_comb begin
    if (ways_r == '0) begin
      cap = lcs_pkg::CNT_W'(1);
    end else if (lcs_pkg::CNT_W'(ways_r) > lcs_pkg::CNT_W'(lcs_pkg::MAX_WAYS)) begin
      cap = lcs_pkg::CNT_W'(lcs_pkg::MAX_WAYS);
    end else begin
      cap = lcs_pkg::CNT_W'(ways_r);
    end
  end

  for (genvar i = 0; i < lcs_pkg::MAX_WAYS; i++) begin : g_cell
    logic [lcs_pkg::TAG_W-1:0] prev_t;
    logic [lcs_pkg::TAG_W-1:0] next_t;
    if (i == 0) begin : g_first
      assign prev_t = cmp.tag;
    end else begin : g_mid
      assign prev_t = cell_tag[i-1];
    end
    if (i == lcs_pkg::MAX_WAYS - 1) begin : g_last
      assign next_t = cell_tag[i];
    end else begin : g_inner
      assign next_t = cell_tag[i+1];
    end
    lcs_cell u_cell (
      .clk      (clk),
      .cell_idx (lcs_pkg::WAY_W'(i)),
      .cmp      (cmp),
      .upd      (upd),
      .prev_tag (prev_t),
      .next_tag (next_t),
      .tag_o    (cell_tag[i]),
      .match_o  (match_vec[i])
    );
  end

  // lowest matching cell wins
  always_comb begin
    hit_pos = '0;
    for (int i = lcs_pkg::MAX_WAYS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_pos = lcs_pkg::WAY_W'(i);
      end
    end
  end

  assign any_hit  = |match_vec;
  assign last_idx = cnt_r - lcs_pkg::CNT_W'(1);

  always_comb begin
    upd.act  = lcs_pkg::ACT_HOLD;
    upd.pos  = '0;
    cnt_nxt  = cnt_r;
    ok_c     = 1'b0;
    hit_c    = 1'b0;
    victim_c = '0;
    case (op)
      lcs_pkg::OP_INSERT: begin
        hit_c = any_hit;
        if (any_hit) begin
          upd.act = lcs_pkg::ACT_PUSH;
          upd.pos = hit_pos;
          ok_c    = 1'b1;
        end else if (cnt_r < cap) begin
          upd.act = lcs_pkg::ACT_PUSH;
          upd.pos = cnt_r[lcs_pkg::WAY_W-1:0];
          cnt_nxt = cnt_r + lcs_pkg::CNT_W'(1);
          ok_c    = 1'b1;
        end
      end
      lcs_pkg::OP_EVICT: begin
        if (cnt_r != '0 && cnt_r >= cap) begin
          victim_c = cell_tag[last_idx[lcs_pkg::WAY_W-1:0]];
          cnt_nxt  = last_idx;
          ok_c     = 1'b1;
        end
      end
      lcs_pkg::OP_LOOKUP: begin
        hit_c = any_hit;
      end
      lcs_pkg::OP_REMOVE: begin
        hit_c = any_hit;
        if (any_hit) begin
          upd.act = lcs_pkg::ACT_CLOSE;
          upd.pos = hit_pos;
          cnt_nxt = last_idx;
          ok_c    = 1'b1;
        end
      end
      default: begin
        hit_c = 1'b0;
      end
    endcase
    if (!accept) begin
      upd.act = lcs_pkg::ACT_HOLD;
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r      <= lcs_pkg::WAYS_CFG_W'(lcs_pkg::MAX_WAYS);
      shift_r     <= lcs_pkg::SHIFT_CFG_W'(6);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lcs_pkg::CFG_WAYS_IN_USE: ways_r  <= cfg_wdata[lcs_pkg::WAYS_CFG_W-1:0];
          lcs_pkg::CFG_TAG_SHIFT:   shift_r <= cfg_wdata[lcs_pkg::SHIFT_CFG_W-1:0];
          default: begin
            ways_r <= ways_r;
          end
        endcase
      end
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r     <= ok_c;
      hit_r    <= hit_c;
      victim_r <= victim_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_hit        = hit_r;
  assign out_victim_tag = victim_r;
  assign out_occupancy  = cnt_r;

endmodule

`default_nettype wire

[hw/rtl/lcs_checker.sv]
// lcs_checker: port-level checks for lru_cache_set_unit, bound to the top level.
// Depends on lcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_ok,
  input logic [lcs_pkg::TAG_W-1:0]      out_victim_tag,
  input logic [lcs_pkg::CNT_W-1:0]      out_occupancy
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // each accepted item shows its result the next cycle
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= lcs_pkg::CNT_W'(lcs_pkg::MAX_WAYS))
    else $error("occupancy beyond set size");

  // a victim only comes with a successful eviction
  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_victim_tag == '0)
    else $error("victim tag without eviction");

endmodule

bind lru_cache_set_unit lcs_checker u_lcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ok         (out_ok),
  .out_victim_tag (out_victim_tag),
  .out_occupancy  (out_occupancy)
);

`default_nettype wire
